FILE: src/prtb_pkg.sv
// Shared types, codes and helper functions of the palette template recolor blend unit.
`timescale 1ns / 1ps

package prtb_pkg;

    // Request codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Configuration register indexes
    localparam int   CFG_IDX_W  = 1;
    localparam int   CFG_DATA_W = 12;
    localparam logic CFG_HEIGHT = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    // Palette entry kinds
    localparam logic [1:0] KIND_OPAQUE = 2'd0;
    localparam logic [1:0] KIND_ALPHA  = 2'd1;

    // First-pass operation on the mask pixel
    localparam logic [1:0] MOP_PASS  = 2'd0;
    localparam logic [1:0] MOP_COPY  = 2'd1;
    localparam logic [1:0] MOP_INDEX = 2'd2;

    // Source of a copied first-pass result
    localparam logic [1:0] SRC_ZERO   = 2'd0;
    localparam logic [1:0] SRC_ABOVE  = 2'd1;
    localparam logic [1:0] SRC_COLUMN = 2'd2;

    localparam logic [23:0] RGB_LIMIT   = 24'h200000;
    localparam logic [23:0] LOW_NIBBLES = 24'h0f0f0f;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        is_pix;
        logic [1:0]  mask_op;
        logic [1:0]  copy_src;
        logic [23:0] mask;
        logic [11:0] mask_idx;
        logic        blend_chk;
        logic [11:0] base_idx;
        logic        wr_ok;
        logic [1:0]  kind;
        logic [31:0] value;
        logic [9:0]  index;
    } prtb_item_t;

    // Palette index from the high nibble of each byte
    function automatic logic [11:0] prtb_idx_of(input logic [23:0] rgb);
        return {rgb[23:20], rgb[15:12], rgb[7:4]};
    endfunction

    // Pixel that may index the palette: small enough and low nibbles clear
    function automatic logic prtb_is_plain(input logic [23:0] rgb);
        return (rgb <= RGB_LIMIT) && ((rgb & LOW_NIBBLES) == 24'd0);
    endfunction

    // One channel of the alpha blend with 8-bit weights
    function automatic logic [7:0] prtb_mix(input logic [7:0] x, input logic [7:0] y,
                                            input logic [7:0] al);
        logic [8:0]  inv;
        logic [16:0] sum;
        inv = 9'd256 - {1'b0, al};
        sum = 17'(x) * 17'(al) + 17'(y) * 17'(inv);
        return sum[15:8];
    endfunction

endpackage

FILE: src/prtb_queue.sv
// Short request queue between the classifying front and the executing back.
`timescale 1ns / 1ps

module prtb_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);
    import prtb_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;

    assign full       = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/prtb_front.sv
// Front end: configuration registers, pixel position tracking and request classification.
`timescale 1ns / 1ps

module prtb_front #(
    parameter int MAX_HEIGHT    = 2048,
    parameter int PALETTE_DEPTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [prtb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [prtb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_cmd,
    input  logic                                s_first_of_image,
    input  logic [23:0]                         s_base_pixel,
    input  logic [23:0]                         s_mask_pixel,
    input  logic [9:0]                          s_entry_index,
    input  logic [1:0]                          s_entry_kind,
    input  logic [31:0]                         s_entry_value,
    output logic                                push,
    output prtb_pkg::prtb_item_t                push_item,
    output logic [$clog2(MAX_HEIGHT)-1:0]       push_row
);
    import prtb_pkg::*;

    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = (HW > 12) ? HW : 12;

    logic [11:0]   height_reg;
    logic [10:0]   count_reg;
    logic [RW-1:0] row_reg, row_next;
    logic          fc_reg, fc_next;
    logic [HW-1:0] fill_reg, fill_next;

    logic [CW-1:0] h_ext, hgt;
    logic [RW-1:0] row_in, row_sel;
    logic          fc_in;
    logic [CW-1:0] row_inc;
    logic          wrap;
    logic [11:0]   mask_idx, base_idx;
    logic          mask_ok, base_ok;

    assign push = s_valid && s_ready;

    always_comb begin
        h_ext = CW'(height_reg);
        if (h_ext == '0) begin
            hgt = CW'(1);
        end else if (h_ext > CW'(MAX_HEIGHT)) begin
            hgt = CW'(MAX_HEIGHT);
        end else begin
            hgt = h_ext;
        end

        row_in  = s_first_of_image ? '0 : row_reg;
        fc_in   = s_first_of_image ? 1'b1 : fc_reg;
        // restart the column when the height shrank below the position
        row_sel = (CW'(row_in) >= hgt) ? '0 : row_in;
        row_inc = CW'(row_sel) + 1'b1;
        wrap    = (row_inc >= hgt);

        row_next  = wrap ? '0 : row_inc[RW-1:0];
        fc_next   = wrap ? 1'b0 : fc_in;
        // rows are always written in order from row 0, so one count covers them
        fill_next = (CW'(fill_reg) < row_inc) ? row_inc[HW-1:0] : fill_reg;

        mask_idx = prtb_idx_of(s_mask_pixel);
        base_idx = prtb_idx_of(s_base_pixel);
        mask_ok  = (mask_idx < {1'b0, count_reg}) && ({20'd0, mask_idx} < PALETTE_DEPTH);
        base_ok  = (base_idx < {1'b0, count_reg}) && ({20'd0, base_idx} < PALETTE_DEPTH);

        push_item.is_pix    = (s_cmd == CMD_PIXEL);
        push_item.mask      = s_mask_pixel;
        push_item.mask_idx  = mask_idx;
        push_item.base_idx  = base_idx;
        push_item.blend_chk = prtb_is_plain(s_base_pixel) && base_ok;
        push_item.wr_ok     = ({22'd0, s_entry_index} < PALETTE_DEPTH);
        push_item.kind      = s_entry_kind;
        push_item.value     = s_entry_value;
        push_item.index     = s_entry_index;

        if (s_mask_pixel > RGB_LIMIT) begin
            push_item.mask_op = MOP_PASS;
        end else if ((s_mask_pixel & LOW_NIBBLES) != 24'd0) begin
            push_item.mask_op = MOP_COPY;
        end else if (mask_ok) begin
            push_item.mask_op = MOP_INDEX;
        end else begin
            push_item.mask_op = MOP_PASS;
        end

        if (fc_in) begin
            push_item.copy_src = (row_sel == '0) ? SRC_ZERO : SRC_ABOVE;
        end else begin
            // a row never written since reset reads as zero
            push_item.copy_src = (CW'(row_sel) < CW'(fill_reg)) ? SRC_COLUMN : SRC_ZERO;
        end

        push_row = row_sel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= 12'd1;
            count_reg  <= '0;
            row_reg    <= '0;
            fc_reg     <= 1'b1;
            fill_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_HEIGHT: height_reg <= cfg_data;
                    CFG_COUNT:  count_reg  <= cfg_data[10:0];
                    default:    ;
                endcase
            end
            if (push && (s_cmd == CMD_PIXEL)) begin
                row_reg  <= row_next;
                fc_reg   <= fc_next;
                fill_reg <= fill_next;
            end
        end
    end

endmodule

FILE: src/prtb_back.sv
// Back end: palette and column memories, first pass, alpha blend and output register.
`timescale 1ns / 1ps

module prtb_back #(
    parameter int MAX_HEIGHT    = 2048,
    parameter int PALETTE_DEPTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  prtb_pkg::prtb_item_t          q_item,
    input  logic [$clog2(MAX_HEIGHT)-1:0] q_row,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [23:0]                   m_color
);
    import prtb_pkg::*;

    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [33:0] pal_mem [PALETTE_DEPTH];
    logic [23:0] col_mem [MAX_HEIGHT];

    logic          b2_valid_reg;
    prtb_item_t    b2_item_reg;
    logic [RW-1:0] b2_row_reg;
    logic [33:0]   pal_a_reg, pal_b_reg;
    logic [23:0]   col_reg;
    logic          fwd_hit_reg;
    logic [23:0]   fwd_data_reg;
    logic [23:0]   above_reg;

    logic          b3_valid_reg;
    logic [23:0]   p3_reg, e3_reg;
    logic [7:0]    al3_reg;
    logic          blend3_reg;

    logic          out_valid_reg;
    logic [23:0]   color_reg;

    logic          out_free, b3_adv, b3_free, b2_adv, b2_free;
    logic          pix_pop, pal_wr;
    logic [23:0]   p2, copy_val, blend_color;
    logic          blend2;

    assign out_free = !out_valid_reg || m_ready;
    assign b3_adv   = b3_valid_reg && out_free;
    assign b3_free  = !b3_valid_reg || out_free;
    assign b2_adv   = b2_valid_reg && b3_free;
    assign b2_free  = !b2_valid_reg || b3_free;
    assign q_pop    = q_valid && (!q_item.is_pix || b2_free);
    assign pix_pop  = q_pop && q_item.is_pix;
    assign pal_wr   = q_pop && !q_item.is_pix && q_item.wr_ok;

    assign m_valid = out_valid_reg;
    assign m_color = color_reg;

    // first pass
    always_comb begin
        case (b2_item_reg.copy_src)
            SRC_ABOVE:  copy_val = above_reg;
            SRC_COLUMN: copy_val = fwd_hit_reg ? fwd_data_reg : col_reg;
            default:    copy_val = 24'd0;
        endcase
        case (b2_item_reg.mask_op)
            MOP_PASS:  p2 = b2_item_reg.mask;
            MOP_COPY:  p2 = copy_val;
            MOP_INDEX: p2 = (pal_a_reg[33:32] == KIND_OPAQUE) ? pal_a_reg[23:0] : 24'd0;
            default:   p2 = 24'd0;
        endcase
        blend2 = b2_item_reg.blend_chk && (pal_b_reg[33:32] == KIND_ALPHA);
    end

    always_comb begin
        if (blend3_reg) begin
            blend_color = {prtb_mix(e3_reg[23:16], p3_reg[23:16], al3_reg),
                           prtb_mix(e3_reg[15:8],  p3_reg[15:8],  al3_reg),
                           prtb_mix(e3_reg[7:0],   p3_reg[7:0],   al3_reg)};
        end else begin
            blend_color = p3_reg;
        end
    end

    // memories: the column write of the leaving pixel and the next read share an edge
    always_ff @(posedge aclk) begin
        if (pal_wr) begin
            pal_mem[AW'(q_item.index)] <= {q_item.kind, q_item.value};
        end
        if (pix_pop) begin
            pal_a_reg <= pal_mem[q_item.mask_idx[AW-1:0]];
            pal_b_reg <= pal_mem[q_item.base_idx[AW-1:0]];
            col_reg   <= col_mem[q_row];
        end
        if (b2_adv) begin
            col_mem[b2_row_reg] <= p2;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_pop) begin
            b2_item_reg  <= q_item;
            b2_row_reg   <= q_row;
            // bypass the column write that lands on the same edge as the read
            fwd_hit_reg  <= b2_valid_reg && (b2_row_reg == q_row);
            fwd_data_reg <= p2;
        end
        if (b2_adv) begin
            p3_reg     <= p2;
            e3_reg     <= pal_b_reg[31:8];
            al3_reg    <= pal_b_reg[7:0];
            blend3_reg <= blend2;
        end
        if (b3_adv) begin
            color_reg <= blend_color;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            above_reg     <= '0;
        end else begin
            if (pix_pop) begin
                b2_valid_reg <= 1'b1;
            end else if (b2_adv) begin
                b2_valid_reg <= 1'b0;
            end
            if (b2_adv) begin
                b3_valid_reg <= 1'b1;
                above_reg    <= p2;
            end else if (b3_adv) begin
                b3_valid_reg <= 1'b0;
            end
            if (b3_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_pix_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_pop |=> b2_valid_reg)
        else $error("popped pixel request did not enter the first-pass stage");

    a_b2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (b2_valid_reg && !b3_free) |=> (b2_valid_reg && $stable(b2_row_reg)))
        else $error("stalled first-pass stage lost its request");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(b3_valid_reg))
        else $error("result appeared without a request in the blend stage");
`endif

endmodule

FILE: src/palette_template_recolor_blend_unit.sv
// Top level of the palette template recolor blend unit.
`timescale 1ns / 1ps

// Recolors a template image streamed in column-major order.
// Input channel s_*: valid/ready requests. s_cmd selects a palette write
// (no result) or a pixel (exactly one result on m_color).
// Configuration port cfg_*: image_height at index 0, palette_count at
// index 1; the user must write them only while the unit is idle, unchecked.
// Throughput: one request per clock while s_ready is high. The front
// classifies each request as it is accepted and pushes it into a four-entry
// queue; the back pops it, reads the palette (two read ports) and the column
// memory, and runs the first pass, the blend stage and the output register.
// When nothing stalls, an accepted pixel passes the queue, the first-pass
// stage, the blend stage and the output register before m_valid rises.
// Reset (aresetn low, synchronous): queue and pipeline empty, position at
// row 0 of the first column, height 1, palette count 0. The palette memory
// holds no defined contents until written; the column memory needs no
// clearing pass, since a row-fill count marks rows not yet written.
// When m_ready is low the result register holds; the pipeline and the queue
// keep filling, and s_ready drops only once the queue is full.
module palette_template_recolor_blend_unit #(
    parameter int PALETTE_DEPTH = 1024,
    parameter int MAX_HEIGHT    = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [prtb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prtb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic                            s_first_of_image,
    input  logic [23:0]                     s_base_pixel,
    input  logic [23:0]                     s_mask_pixel,
    input  logic [9:0]                      s_entry_index,
    input  logic [1:0]                      s_entry_kind,
    input  logic [31:0]                     s_entry_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [23:0]                     m_color
);
    import prtb_pkg::*;

    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int IW = $bits(prtb_item_t);
    localparam int QW = IW + RW;

    logic          push, q_full, q_valid, q_pop;
    prtb_item_t    push_item, q_item;
    logic [RW-1:0] push_row, q_row;
    logic [QW-1:0] q_head;

    assign s_ready = !q_full;
    assign q_item  = q_head[IW-1:0];
    assign q_row   = q_head[QW-1:IW];

    prtb_front #(
        .MAX_HEIGHT    (MAX_HEIGHT),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_first_of_image (s_first_of_image),
        .s_base_pixel     (s_base_pixel),
        .s_mask_pixel     (s_mask_pixel),
        .s_entry_index    (s_entry_index),
        .s_entry_kind     (s_entry_kind),
        .s_entry_value    (s_entry_value),
        .push             (push),
        .push_item        (push_item),
        .push_row         (push_row)
    );

    prtb_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  ({push_row, push_item}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    prtb_back #(
        .MAX_HEIGHT    (MAX_HEIGHT),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_row   (q_row),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_color (m_color)
    );

endmodule
